[rtl/bcs_pkg.sv]
// ---------------------------------------------------------------------------
// bcs_pkg
// shared constants and types for the brightness / contrast / saturation map
// ---------------------------------------------------------------------------
package bcs_pkg;

   // offset-binary code limits
   localparam int CODE_W   = 8;
   localparam int MID_CODE = 128;
   localparam int MAX_CODE = 255;

   // quotient bits of the stretch divide: (|d| * 128) needs 15 bits
   localparam int DIV_BITS = 15;
   // entry stage + one stage per quotient bit + sum and clamp stage
   localparam int CHAN_LAT = DIV_BITS + 2;

   // register indexes of the control port
   localparam int CSR_ADDR_W = 2;
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BRIGHTNESS = 2'd0,
      CSR_CONTRAST   = 2'd1,
      CSR_SATURATION = 2'd2
   } csr_addr_type;

   // per-stage side information of one channel
   typedef struct packed {
      logic                neg;      // code below mid level
      logic                stretch;  // setting is non-negative
      logic [7:0]          divisor;  // 128 - setting, 1..128 when stretching
      logic signed [9:0]   shiftv;   // d - setting, used when setting is negative
      logic [DIV_BITS-1:0] num;      // |d| * 128
   } stage_type;

endpackage

[rtl/brightness_contrast_saturation_map_core.sv]
// pipeline: an accepted input word passes the entry stage, the divide stages and
// the sum and clamp stage; a held result word freezes the pipeline; a word caught
// in the skid register during such a stall enters the first stage when it ends
// throughput: one word per clock unless a held result word stalls; the 15-stage
// restoring divide of each channel is fully pipelined, one quotient bit per stage
// reset: synchronous, active high; clears valid bits, the skid valid bit and the
// three settings to zero
// ---------------------------------------------------------------------------
// brightness_contrast_saturation_map_core
// luma brightness/contrast, chroma saturation; unless stalled, one pixel per clock
// ---------------------------------------------------------------------------
module brightness_contrast_saturation_map_core (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] luma_in, [15:8] chroma_in
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] luma_out, [15:8] chroma_out
   // control registers
   input  logic                             csr_we,
   input  logic [bcs_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [7:0]                       csr_wdata
);

   localparam int LAT = bcs_pkg::CHAN_LAT;

   logic signed [7:0] bright_ff, contrast_ff, satur_ff;
   logic              skid_vld_ff;
   logic [15:0]       skid_data_ff;
   logic [LAT-1:0]    vld_ff;

   logic              en;
   logic              req_take;
   logic              src_vld;
   logic [15:0]       src_data;
   logic [7:0]        luma_res, chroma_res;

   // settings registers, writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff   <= '0;
         contrast_ff <= '0;
         satur_ff    <= '0;
      end else if (csr_we) begin
         case (bcs_pkg::csr_addr_type'(csr_addr))
            bcs_pkg::CSR_BRIGHTNESS: bright_ff   <= csr_wdata;
            bcs_pkg::CSR_CONTRAST:   contrast_ff <= csr_wdata;
            bcs_pkg::CSR_SATURATION: satur_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advances unless the result word is stuck
   assign en       = ~vld_ff[LAT-1] | rsp_tready;
   assign req_tready = ~skid_vld_ff;
   assign req_take = req_tvalid & req_tready;
   assign src_vld  = skid_vld_ff | req_take;
   assign src_data = skid_vld_ff ? skid_data_ff : req_tdata;

   // skid register catches a word taken during a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (en) begin
         skid_vld_ff <= 1'b0;
      end else if (req_take) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && req_take) begin
         skid_data_ff <= req_tdata;
      end
   end

   // valid bits travel beside the channel stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], src_vld};
      end
   end

   // luma: brightness offset, contrast stretch
   bcs_chan u_luma (
      .clock    (clock),
      .en       (en),
      .code_in  (src_data[7:0]),
      .setting  (contrast_ff),
      .offset   (bright_ff),
      .code_out (luma_res)
   );

   // chroma: saturation stretch, no offset
   bcs_chan u_chroma (
      .clock    (clock),
      .en       (en),
      .code_in  (src_data[15:8]),
      .setting  (satur_ff),
      .offset   (8'sd0),
      .code_out (chroma_res)
   );

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {chroma_res, luma_res};

endmodule

[rtl/bcs_chan.sv]
// ---------------------------------------------------------------------------
// bcs_chan
// one channel: offset removal, pipelined restoring divide, offset add, clamp
// ---------------------------------------------------------------------------
module bcs_chan (
   input  logic                           clock,
   input  logic                           en,        // pipeline advance
   input  logic [bcs_pkg::CODE_W-1:0]     code_in,
   input  logic signed [7:0]              setting,   // contrast or saturation
   input  logic signed [7:0]              offset,    // brightness, or zero
   output logic [bcs_pkg::CODE_W-1:0]     code_out
);

   localparam int NB = bcs_pkg::DIV_BITS;

   bcs_pkg::stage_type st_ff  [0:NB];
   logic [6:0]         rem_ff [0:NB];
   logic [NB-1:0]      quo_ff [0:NB];
   logic [bcs_pkg::CODE_W-1:0] code_ff;

   bcs_pkg::stage_type st_in;
   logic [6:0]         rem_in [1:NB];
   logic [NB-1:0]      quo_in [1:NB];
   logic [bcs_pkg::CODE_W-1:0] code_in_c;

   logic [7:0]         mag;
   logic [7:0]         trial  [1:NB];
   logic               ge     [1:NB];
   logic signed [16:0] qs;
   logic signed [16:0] adj;
   logic signed [16:0] sum;

   // entry stage: magnitude, sign and both candidate paths
   always_comb begin
      mag = code_in[7] ? {1'b0, code_in[6:0]}
                       : 8'(bcs_pkg::MID_CODE) - code_in;
      st_in.neg     = ~code_in[7];
      st_in.stretch = ~setting[7];
      st_in.divisor = 8'(bcs_pkg::MID_CODE) - setting;
      st_in.shiftv  = $signed({2'b00, code_in}) - 10'sd128
                      - {{2{setting[7]}}, setting};
      st_in.num     = {mag, 7'b0000000};
   end

   // one quotient bit per stage, msb first
   always_comb begin
      for (int s = 1; s <= NB; s++) begin
         trial[s]  = {rem_ff[s-1], st_ff[s-1].num[NB-s]};
         ge[s]     = (trial[s] >= st_ff[s-1].divisor);
         rem_in[s] = ge[s] ? 7'(trial[s] - st_ff[s-1].divisor) : trial[s][6:0];
         quo_in[s] = {quo_ff[s-1][NB-2:0], ge[s]};
      end
   end

   // restore sign, add offsets and clamp to the code range
   always_comb begin
      qs  = st_ff[NB].neg ? -$signed({2'b00, quo_ff[NB]}) : $signed({2'b00, quo_ff[NB]});
      adj = st_ff[NB].stretch ? qs : {{7{st_ff[NB].shiftv[9]}}, st_ff[NB].shiftv};
      sum = adj + 17'sd128 + {{9{offset[7]}}, offset};
      if (sum < 17'sd0) begin
         code_in_c = '0;
      end else if (sum > 17'(bcs_pkg::MAX_CODE)) begin
         code_in_c = 8'(bcs_pkg::MAX_CODE);
      end else begin
         code_in_c = sum[7:0];
      end
   end

   // stage registers, all held on a stall
   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0]  <= st_in;
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
         for (int s = 1; s <= NB; s++) begin
            st_ff[s]  <= st_ff[s-1];
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
         end
         code_ff <= code_in_c;
      end
   end

   assign code_out = code_ff;

endmodule
